// File: hw/rtl/slcrx_pkg.sv
// ----------------------------------------------------------------------------
// slcrx_pkg
// Shared types, constants and the byte-wise CRC-16 update for the frame
// receiver.
// ----------------------------------------------------------------------------
package slcrx_pkg;

  localparam logic [31:0] SYNC_WORD      = 32'hBEEF_DEAD;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd1990;
  localparam logic [15:0] HDR_LAST_COUNT = 16'd5;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_OK        = 3'd1,
    KIND_BAD_START = 3'd2,
    KIND_BAD_CRC   = 3'd3,
    KIND_TOO_LONG  = 3'd4
  } kind_t;

  // one result item, plus whether the processed byte produced one
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] len;
  } result_t;

  // reflected ccitt crc-16, byte-wise update (0x8408 form)
  function automatic logic [15:0] crc16_update(input logic [15:0] seed,
                                               input logic [7:0]  b);
    logic [7:0]  a;
    logic [3:0]  lo;
    logic [7:0]  m;
    logic [3:0]  s;
    logic [8:0]  ms;
    logic [15:0] t1;
    logic [12:0] tx;
    logic [15:0] t2;
    a  = seed[7:0] ^ b;
    lo = a[3:0];
    m  = {lo, 4'b0000} ^ a;
    s  = m[7:4];
    ms = {m, 1'b0} ^ {5'b00000, s};
    t1 = {3'b000, ms, 4'b0000};
    tx = t1[12:0] ^ {9'b0, lo};
    t2 = {tx, 3'b000};
    return t2 ^ {12'b0, s} ^ {8'b0, seed[15:8]};
  endfunction

endpackage

// File: hw/rtl/slcrx_ctrl.sv
// ----------------------------------------------------------------------------
// slcrx_ctrl
// Frame state machine: header shift, length check, crc accumulation and
// end-of-frame compare; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module slcrx_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         max_length,
  output slcrx_pkg::result_t  res
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC_HI  = 2'd2,
    PH_CRC_LO  = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [47:0] hdr_r, hdr_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;

  logic [15:0] crc_upd;
  logic [15:0] cnt_inc;
  logic [47:0] hdr_shift;
  logic [15:0] hdr_len;

  assign crc_upd   = slcrx_pkg::crc16_update(crc_r, rx_byte);
  assign cnt_inc   = cnt_r + 16'd1;
  assign hdr_shift = {hdr_r[39:0], rx_byte};
  assign hdr_len   = hdr_shift[15:0];

  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    crc_hi_nxt = crc_hi_r;
    res        = '0;
    res.kind   = slcrx_pkg::KIND_DATA;
    unique case (phase_r)
      PH_PAYLOAD: begin
        crc_nxt   = crc_upd;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_CRC_HI;
        end
        res.valid = 1'b1;
        res.data  = rx_byte;
      end
      PH_CRC_HI: begin
        crc_hi_nxt = rx_byte;
        phase_nxt  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        res.valid = 1'b1;
        res.kind  = ({crc_hi_r, rx_byte} == crc_r) ? slcrx_pkg::KIND_OK
                                                   : slcrx_pkg::KIND_BAD_CRC;
        res.len   = len_r;
        phase_nxt = PH_HEADER;
        hdr_nxt   = '0;
        cnt_nxt   = '0;
        crc_nxt   = '0;
      end
      default: begin
        hdr_nxt = hdr_shift;
        crc_nxt = crc_upd;
        cnt_nxt = cnt_inc;
        if (cnt_r == slcrx_pkg::HDR_LAST_COUNT) begin
          len_nxt = hdr_len;
          if (hdr_shift[47:16] != slcrx_pkg::SYNC_WORD) begin
            res.valid = 1'b1;
            res.kind  = slcrx_pkg::KIND_BAD_START;
            res.len   = hdr_len;
            hdr_nxt   = '0;
            cnt_nxt   = '0;
            crc_nxt   = '0;
          end else if (hdr_len > max_length) begin
            res.valid = 1'b1;
            res.kind  = slcrx_pkg::KIND_TOO_LONG;
            res.len   = hdr_len;
            hdr_nxt   = '0;
            cnt_nxt   = '0;
            crc_nxt   = '0;
          end else begin
            cnt_nxt   = '0;
            phase_nxt = (hdr_len == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
          end
        end
      end
    endcase
    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hdr_r    <= '0;
      cnt_r    <= '0;
      len_r    <= '0;
      crc_r    <= '0;
      crc_hi_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      hdr_r    <= hdr_nxt;
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

  // frame end always restarts a clean header
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_CRC_LO |=> phase_r == PH_HEADER && cnt_r == 16'd0 &&
      crc_r == 16'd0)
    else $error("frame end did not restart header");

  // header count never reaches the header size
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> cnt_r <= slcrx_pkg::HDR_LAST_COUNT)
    else $error("header byte count out of range");

  // payload phase only while bytes are still owed
  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> cnt_r < len_r)
    else $error("payload count past length");

endmodule

// File: hw/rtl/slcrx_out_stage.sv
// ----------------------------------------------------------------------------
// slcrx_out_stage
// Result register toward the output channel; tells the core when a new
// result may be loaded.
// ----------------------------------------------------------------------------
module slcrx_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  slcrx_pkg::result_t res,
  output logic               load_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_payload_byte,
  output logic [15:0]        out_frame_length
);

  logic        valid_r;
  logic [2:0]  kind_r;
  logic [7:0]  data_r;
  logic [15:0] len_r;

  assign load_ok = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && res.valid) begin
      kind_r <= res.kind;
      data_r <= res.data;
      len_r  <= res.len;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = data_r;
  assign out_frame_length = len_r;

endmodule

// File: hw/rtl/sync_length_crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_receiver
// Byte-stream deframer: sync BE EF DE AD, 16-bit length, payload, crc-16.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and splits the stream into frames of a
// six-byte header (sync BE EF DE AD, big-endian length), the payload and a
// big-endian reflected ccitt crc-16 (seed 0) over header and payload. Each
// payload byte comes out as a kind 0 item as it arrives; the frame closes
// with kind 1 (crc ok) or kind 3 (bad crc). A header with wrong sync gives
// kind 2, one whose length exceeds max_length gives kind 4, and in both cases
// a new header starts at the next byte. Throughput is one byte per cycle;
// a byte that yields a result reaches out_valid through the input register
// and then the result register, fed by the combinational header/crc update.
// Backpressure on the output stalls the input once both registers are full.
// max_length resets to 1990 and is written through the cfg channel, which is
// always ready; write it only while the block is idle.
module sync_length_crc16_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_frame_length,
  // max_length register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_length
);

  // configuration
  logic [15:0] max_len_r;

  // input register
  logic        in_v_r;
  logic [7:0]  in_byte_r;

  // handshake between stages
  logic               load_ok;
  logic               step;
  slcrx_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= slcrx_pkg::MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_len_r <= cfg_max_length;
    end
  end

  // byte moves into the core when the result register can take its result
  assign step     = in_v_r && load_ok;
  assign in_ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // header / payload / crc state machine
  slcrx_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (in_byte_r),
    .max_length (max_len_r),
    .res        (res)
  );

  // result register
  slcrx_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .load_ok          (load_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_length (out_frame_length)
  );

endmodule

// File: sim/sync_length_crc16_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_receiver_tb
// Self-checking bench for the sync/length/crc-16 frame receiver.
// ----------------------------------------------------------------------------
// Builds byte streams of whole frames (good, bad crc, bad sync, over-length
// headers) mixed with random noise, feeds them through the byte channel with
// random gaps, and stalls the result channel at random. A cycle-free model of
// the deframer predicts every result item as each byte is taken; results are
// checked in order, field by field. max_length is rewritten between phases
// while the block is idle, covering zero and 65534 as well as small limits.
module sync_length_crc16_frame_receiver_tb;

  localparam int          STALL_LIMIT   = 2000;  // cycles with no item moving
  localparam int          SETTLE_CYCLES = 6;     // pipeline depth plus margin
  localparam int          TAIL_CYCLES   = 12;
  localparam int          HDR_BYTES     = 6;
  localparam int          MAX_PRINTS    = 20;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO
  } rx_phase_t;

  // how a generated frame is damaged, if at all
  typedef enum logic [1:0] {
    FLAW_NONE,
    FLAW_CRC,
    FLAW_SYNC,
    FLAW_LENGTH
  } frame_flaw_t;

  typedef struct packed {
    slcrx_pkg::kind_t kind;
    logic [7:0]       payload;
    logic [15:0]      len;
  } rx_result_t;

  // dut ports; the driven inputs are known from time zero
  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte       = 8'h00;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_frame_length;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_max_length   = 16'h0000;

  // byte stream waiting to be driven, and results owed by the block
  logic [7:0]  rx_stream[$];
  rx_result_t  due_results[$];

  // deframer state as the block should hold it
  rx_phase_t   rx_phase;
  logic [47:0] hdr_shift;
  logic [15:0] taken_count;
  logic [15:0] frame_len_q;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi_rx;
  logic [15:0] max_len_cfg;

  // driver / stall bookkeeping
  logic        in_took   = 1'b0;
  int          in_gap    = 0;
  bit          in_calm   = 1'b0;
  int          out_hold  = 0;
  bit          out_calm  = 1'b0;

  // run statistics
  int          fail_count     = 0;
  int          results_seen   = 0;
  int          bytes_taken    = 0;
  int          bytes_queued   = 0;
  int          frames_queued  = 0;
  int          settings_used  = 1;
  int          kind_seen[5]   = '{default: 0};
  int          cur_max;

  wire any_item = (in_valid && in_ready) || (out_valid && out_ready) ||
                  (cfg_valid && cfg_ready);

  sync_length_crc16_frame_receiver u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_length   (cfg_max_length)
  );

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk = ~clk;
  end

  // reset held, then released away from the sampling edge
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  // bit-serial reflected ccitt crc, lsb first
  function automatic logic [15:0] crc_ccitt_refl(input logic [15:0] seed,
                                                 input logic [7:0]  b);
    logic [15:0] c;
    c = seed ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY_REFL;
      else      c = c >> 1;
    end
    return c;
  endfunction

  function automatic void expect_result(input slcrx_pkg::kind_t k,
                                        input logic [7:0] d,
                                        input logic [15:0] len);
    rx_result_t r;
    r.kind    = k;
    r.payload = d;
    r.len     = len;
    due_results.push_back(r);
  endfunction

  // back to the header phase; the length of the last frame is kept
  function automatic void restart_header();
    rx_phase    = PH_HEADER;
    hdr_shift   = '0;
    taken_count = '0;
    crc_acc     = '0;
  endfunction

  // advance the deframer by one received byte, queue what it owes
  function automatic void deframe_byte(input logic [7:0] b);
    logic [15:0] got;
    case (rx_phase)
      PH_PAYLOAD: begin
        crc_acc     = crc_ccitt_refl(crc_acc, b);
        taken_count = taken_count + 16'd1;
        if (taken_count >= frame_len_q) rx_phase = PH_CRC_HI;
        expect_result(slcrx_pkg::KIND_DATA, b, 16'd0);
      end
      PH_CRC_HI: begin
        crc_hi_rx = b;
        rx_phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        got = {crc_hi_rx, b};
        if (got == crc_acc) expect_result(slcrx_pkg::KIND_OK, 8'd0, frame_len_q);
        else                expect_result(slcrx_pkg::KIND_BAD_CRC, 8'd0, frame_len_q);
        restart_header();
      end
      default: begin
        hdr_shift   = {hdr_shift[39:0], b};
        crc_acc     = crc_ccitt_refl(crc_acc, b);
        taken_count = taken_count + 16'd1;
        rx_phase    = PH_HEADER;
        if (taken_count >= 16'(HDR_BYTES)) begin
          frame_len_q = hdr_shift[15:0];
          // sync is judged before the length limit
          if (hdr_shift[47:16] != slcrx_pkg::SYNC_WORD) begin
            restart_header();
            expect_result(slcrx_pkg::KIND_BAD_START, 8'd0, frame_len_q);
          end else if (frame_len_q > max_len_cfg) begin
            restart_header();
            expect_result(slcrx_pkg::KIND_TOO_LONG, 8'd0, frame_len_q);
          end else begin
            taken_count = '0;
            // zero-length frames skip straight to the crc bytes
            if (frame_len_q == 16'd0) rx_phase = PH_CRC_HI;
            else                      rx_phase = PH_PAYLOAD;
          end
        end
      end
    endcase
  endfunction

  initial begin
    max_len_cfg = slcrx_pkg::MAX_LEN_RESET;
    frame_len_q = '0;
    crc_hi_rx   = '0;
    restart_header();
  end

  // --------------------------------------------------------------------------
  // idle lengths: mostly none, some short, a few long; calm stretches have none
  // --------------------------------------------------------------------------
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // byte driver, fed from rx_stream
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (rx_stream.size() > 0) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_stream.pop_front();
        in_gap     <= idle_len(in_calm);
        if ($urandom_range(0, 63) == 0) in_calm <= !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold  <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      out_hold  <= idle_len(out_calm);
      if ($urandom_range(0, 63) == 0) out_calm <= !out_calm;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check results, track config writes, predict on taken bytes
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("mismatch on result %0d: %s", results_seen, msg);
  endtask

  always @(posedge clk) begin : monitor
    rx_result_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      // an output item always stems from a byte taken before it
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected item kind %0d len %0d",
                                    out_kind, out_frame_length));
        end else begin
          want = due_results.pop_front();
          kind_seen[want.kind]++;
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_payload_byte !== want.payload)
            report_mismatch($sformatf("payload_byte %02h, want %02h",
                                      out_payload_byte, want.payload));
          if (out_frame_length !== want.len)
            report_mismatch($sformatf("frame_length %0d, want %0d",
                                      out_frame_length, want.len));
        end
      end
      if (cfg_valid && cfg_ready) max_len_cfg = cfg_max_length;
      if (in_valid && in_ready) begin
        bytes_taken++;
        deframe_byte(in_rx_byte);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: give up when nothing moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (any_item) quiet = 0;
      else          quiet++;
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endfunction

  // one frame; sync and length flaws stop after the header, as the block does
  function automatic void queue_frame(input logic [15:0] len,
                                      input frame_flaw_t flaw);
    logic [31:0] sync;
    logic [15:0] crc;
    logic [7:0]  hdr[6];
    logic [7:0]  b;
    sync = slcrx_pkg::SYNC_WORD;
    crc  = '0;
    if (flaw == FLAW_SYNC) sync ^= 32'h1 << $urandom_range(0, 31);
    hdr = '{sync[31:24], sync[23:16], sync[15:8], sync[7:0], len[15:8], len[7:0]};
    frames_queued++;
    foreach (hdr[i]) begin
      push_byte(hdr[i]);
      crc = crc_ccitt_refl(crc, hdr[i]);
    end
    if (flaw == FLAW_SYNC || flaw == FLAW_LENGTH) return;
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom_range(0, 255));
      push_byte(b);
      crc = crc_ccitt_refl(crc, b);
    end
    if (flaw == FLAW_CRC) crc ^= 16'h1 << $urandom_range(0, 15);
    push_byte(crc[15:8]);
    push_byte(crc[7:0]);
  endfunction

  // payload sizes kept small, capped at the limit or 64; the cap itself is hit now and then
  function automatic logic [15:0] pick_length(input int limit);
    int cap;
    int r;
    r   = $urandom_range(0, 99);
    cap = (limit < 64) ? limit : 64;
    if (r < 55) return 16'($urandom_range(0, (cap < 8) ? cap : 8));
    if (r < 85) return 16'($urandom_range(0, cap));
    return 16'(cap);
  endfunction

  // mostly well-formed frames, the rest broken headers and line noise
  task automatic queue_random_traffic(input int n_bytes);
    int          start;
    int          r;
    logic [15:0] len;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        queue_frame(pick_length(cur_max), FLAW_NONE);
      end else if (r < 67) begin
        queue_frame(pick_length(cur_max), FLAW_CRC);
      end else if (r < 77) begin
        queue_frame(16'($urandom_range(0, 65535)), FLAW_SYNC);
      end else if (r < 87) begin
        // just over the limit, or anywhere above it
        if ($urandom_range(0, 1) == 1) len = 16'(cur_max + 1);
        else                           len = 16'($urandom_range(cur_max + 1, 65535));
        queue_frame(len, FLAW_LENGTH);
      end else begin
        // a header's worth of noise keeps later frames aligned
        repeat (HDR_BYTES) push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    while (rx_stream.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_max_length <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] settings[4];
    settings = '{16'd0, 16'd65534, 16'd7, 16'($urandom_range(1, 40))};
    cur_max  = slcrx_pkg::MAX_LEN_RESET;
    @(posedge rst_n);

    // directed: empty frame with bad crc, one-byte good frame,
    // bad sync and over-length headers with the largest length field
    queue_frame(16'd0, FLAW_CRC);
    queue_frame(16'd1, FLAW_NONE);
    queue_frame(16'hFFFF, FLAW_SYNC);
    queue_frame(16'hFFFF, FLAW_LENGTH);
    queue_random_traffic(170);

    // remaining max_length settings, each written while the block is idle
    foreach (settings[k]) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_max_length(settings[k]);
      cur_max = settings[k];
      settings_used++;
      queue_random_traffic(200);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d frames over %0d max_length settings, %0d results",
             bytes_taken, frames_queued, settings_used, results_seen);
    $display("ends: %0d ok, %0d bad crc, %0d bad start, %0d too long; %0d mismatches",
             kind_seen[slcrx_pkg::KIND_OK], kind_seen[slcrx_pkg::KIND_BAD_CRC],
             kind_seen[slcrx_pkg::KIND_BAD_START], kind_seen[slcrx_pkg::KIND_TOO_LONG],
             fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
